FILE: sv/tile_background_video_unit_defines.svh
// Assertion macros for the tile background video unit.
// Included by the top level; no other dependencies.
`ifndef TILE_BACKGROUND_VIDEO_UNIT_DEFINES_SVH
`define TILE_BACKGROUND_VIDEO_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// expr must never hold outside reset
`define TVU_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tvu assertion failed");

// ante at one edge implies cons at the next edge
`define TVU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvu assertion failed");

`else

`define TVU_ASSERT_NEVER(label, clk, rst_n, expr)
`define TVU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/tvu_pkg.sv
// Shared types and constants for the tile background video unit.
// No dependencies.
package tvu_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_LOAD  = 2'd3
    } tvu_cmd_t;

    // CPU-visible register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // configuration register indexes
    localparam logic CFG_MIRROR     = 1'b0;
    localparam logic CFG_PATTERN_RO = 1'b1;

    // video memory map
    localparam logic [13:0] NT_BASE  = 14'h2000;
    localparam logic [13:0] PAL_BASE = 14'h3F00;

    localparam logic [8:0] PRE_LINE = 9'd261;

    // where the byte read for an item comes from
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_PAT,
        SRC_NT,
        SRC_OAM,
        SRC_PAL
    } tvu_src_t;

    // raster, scroll and background pipeline state
    typedef struct packed {
        logic [8:0]  dot;
        logic [8:0]  line;
        logic [15:0] v;
        logic [15:0] t;
        logic [2:0]  fx;
        logic [7:0]  ctrl;
        logic [7:0]  mask;
        logic        vblank;
        logic [7:0]  tile_id;
        logic [1:0]  tile_attr;
        logic [7:0]  pat_lo;
        logic [7:0]  pat_hi;
        logic [15:0] sh_pl;
        logic [15:0] sh_ph;
        logic [15:0] sh_al;
        logic [15:0] sh_ah;
    } tvu_raster_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        pixel_valid;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [5:0]  color_index;
        logic [23:0] pixel_rgb;
        logic        nmi_pulse;
        logic        frame_done;
    } tvu_result_t;

endpackage

FILE: sv/tvu_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tvu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tvu_render.sv
// Dot tick datapath: raster counters, fetch sequencing, shifters, pixel color.
// Depends on tvu_pkg.
module tvu_render (
    input  tvu_pkg::tvu_raster_t state,
    input  logic [7:0]           fetch_data,
    input  logic [7:0]           pal_data,
    output logic [4:0]           pal_index,
    output tvu_pkg::tvu_raster_t state_next,
    output tvu_pkg::tvu_result_t tick_result
);
    import tvu_pkg::*;

    logic [8:0]  d;
    logic [8:0]  l;
    logic [8:0]  d_minus;
    logic [2:0]  phase;
    logic        fetch_line;
    logic        in_fetch;
    logic        rend;
    logic [7:0]  at;
    logic [3:0]  bitpos;
    logic [1:0]  pix;
    logic [1:0]  pal;
    tvu_raster_t n;
    tvu_result_t res;

    function automatic logic [15:0] step_x(input logic [15:0] v);
        logic [15:0] r;
        if (v[4:0] == 5'd31)
        begin
            r = {v[15:5], 5'd0} ^ 16'h0400;
        end
        else
        begin
            r = v + 16'd1;
        end
        return r;
    endfunction

    function automatic logic [15:0] step_y(input logic [15:0] v);
        logic [15:0] r;
        logic [4:0]  y;
        r = v;
        y = v[9:5];
        if (v[14:12] != 3'b111)
        begin
            r = v + 16'h1000;
        end
        else
        begin
            r[14:12] = 3'd0;
            if (y == 5'd29)
            begin
                y = 5'd0;
                r[11] = ~r[11];
            end
            else if (y == 5'd31)
            begin
                y = 5'd0;
            end
            else
            begin
                y = y + 5'd1;
            end
            r[9:5] = y;
        end
        return r;
    endfunction

    function automatic logic [23:0] rgb_lookup(input logic [5:0] ci);
        logic [23:0] c;
        case (ci)
            6'd0:  c = 24'h757575;  6'd1:  c = 24'h271B8F;  6'd2:  c = 24'h0000AB;
            6'd3:  c = 24'h47009F;  6'd4:  c = 24'h8F0077;  6'd5:  c = 24'hAB0013;
            6'd6:  c = 24'hA70000;  6'd7:  c = 24'h7F0B00;  6'd8:  c = 24'h432F00;
            6'd9:  c = 24'h004700;  6'd10: c = 24'h005100;  6'd11: c = 24'h003F17;
            6'd12: c = 24'h1B3F5F;  6'd16: c = 24'hBCBCBC;  6'd17: c = 24'h0073EF;
            6'd18: c = 24'h233BEF;  6'd19: c = 24'h8300F3;  6'd20: c = 24'hBF00BF;
            6'd21: c = 24'hE7005B;  6'd22: c = 24'hDB2B00;  6'd23: c = 24'hCB4F0F;
            6'd24: c = 24'h8B7300;  6'd25: c = 24'h009700;  6'd26: c = 24'h00AB00;
            6'd27: c = 24'h00933B;  6'd28: c = 24'h00838B;  6'd32: c = 24'hFFFFFF;
            6'd33: c = 24'h3FBFFF;  6'd34: c = 24'h5F97FF;  6'd35: c = 24'hA78BFD;
            6'd36: c = 24'hF77BFF;  6'd37: c = 24'hFF77B7;  6'd38: c = 24'hFF7763;
            6'd39: c = 24'hFF9B3B;  6'd40: c = 24'hF3BF3F;  6'd41: c = 24'h83D313;
            6'd42: c = 24'h4FDF4B;  6'd43: c = 24'h58F898;  6'd44: c = 24'h00EBDB;
            6'd48: c = 24'hFFFFFF;  6'd49: c = 24'hABE7FF;  6'd50: c = 24'hC7D7FF;
            6'd51: c = 24'hD7CBFF;  6'd52: c = 24'hFFC7FF;  6'd53: c = 24'hFFC7DB;
            6'd54: c = 24'hFFBFB3;  6'd55: c = 24'hFFDBAB;  6'd56: c = 24'hFFE7A3;
            6'd57: c = 24'hE3FFA3;  6'd58: c = 24'hABF3BF;  6'd59: c = 24'hB3FFCF;
            6'd60: c = 24'h9FFFF3;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    assign d          = state.dot;
    assign l          = state.line;
    assign d_minus    = d - 9'd1;
    assign phase      = d_minus[2:0];
    assign fetch_line = (l < 9'd240) || (l == PRE_LINE);
    assign in_fetch   = ((d >= 9'd2) && (d <= 9'd257)) || ((d >= 9'd321) && (d <= 9'd337));
    assign rend       = state.mask[3] | state.mask[4];

    always_comb
    begin
        n   = state;
        res = '0;
        at  = fetch_data;

        // vertical blank start and end
        if ((l == 9'd241) && (d == 9'd1))
        begin
            n.vblank      = 1'b1;
            res.nmi_pulse = state.ctrl[7];
        end
        if ((l == PRE_LINE) && (d == 9'd1))
        begin
            n.vblank = 1'b0;
        end

        if (fetch_line)
        begin
            if (in_fetch)
            begin
                if (state.mask[3])
                begin
                    n.sh_pl = {state.sh_pl[14:0], 1'b0};
                    n.sh_ph = {state.sh_ph[14:0], 1'b0};
                    n.sh_al = {state.sh_al[14:0], 1'b0};
                    n.sh_ah = {state.sh_ah[14:0], 1'b0};
                end
                // eight-dot fetch sequence
                case (phase)
                    3'd0:
                    begin
                        n.sh_pl   = {n.sh_pl[15:8], state.pat_lo};
                        n.sh_ph   = {n.sh_ph[15:8], state.pat_hi};
                        n.sh_al   = {n.sh_al[15:8], {8{state.tile_attr[0]}}};
                        n.sh_ah   = {n.sh_ah[15:8], {8{state.tile_attr[1]}}};
                        n.tile_id = fetch_data;
                    end
                    3'd2:
                    begin
                        if (state.v[6])
                        begin
                            at = at >> 4;
                        end
                        if (state.v[1])
                        begin
                            at = at >> 2;
                        end
                        n.tile_attr = at[1:0];
                    end
                    3'd4:
                    begin
                        n.pat_lo = fetch_data;
                    end
                    3'd6:
                    begin
                        n.pat_hi = fetch_data;
                    end
                    3'd7:
                    begin
                        if (rend)
                        begin
                            n.v = step_x(n.v);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if ((d == 9'd256) && rend)
            begin
                n.v = step_y(n.v);
            end
            // end of line: reload shifters, copy horizontal scroll
            if (d == 9'd257)
            begin
                n.sh_pl = {n.sh_pl[15:8], n.pat_lo};
                n.sh_ph = {n.sh_ph[15:8], n.pat_hi};
                n.sh_al = {n.sh_al[15:8], {8{n.tile_attr[0]}}};
                n.sh_ah = {n.sh_ah[15:8], {8{n.tile_attr[1]}}};
                if (rend)
                begin
                    n.v = (n.v & 16'hFBE0) | (state.t & 16'h041F);
                end
            end
            // pre-render line: copy vertical scroll
            if ((l == PRE_LINE) && (d >= 9'd280) && (d <= 9'd304) && rend)
            begin
                n.v = (n.v & 16'h841F) | (state.t & 16'h7BE0);
            end
        end

        // background pixel select
        bitpos = 4'd15 - {1'b0, state.fx};
        pix    = 2'd0;
        pal    = 2'd0;
        if (state.mask[3])
        begin
            pix = {n.sh_ph[bitpos], n.sh_pl[bitpos]};
            pal = {n.sh_ah[bitpos], n.sh_al[bitpos]};
        end
        pal_index = (pix == 2'd0) ? 5'd0 : {1'b0, pal, pix};

        if ((l < 9'd240) && (d >= 9'd1) && (d <= 9'd256))
        begin
            res.pixel_valid = 1'b1;
            res.pixel_x     = d_minus[7:0];
            res.pixel_y     = l[7:0];
            res.color_index = pal_data[5:0];
            res.pixel_rgb   = rgb_lookup(pal_data[5:0]);
        end

        // raster counters
        if (d == 9'd340)
        begin
            n.dot = 9'd0;
            if (l == PRE_LINE - 9'd1)
            begin
                n.line         = PRE_LINE;
                res.frame_done = 1'b1;
            end
            else if (l >= PRE_LINE)
            begin
                n.line = 9'd0;
            end
            else
            begin
                n.line = l + 9'd1;
            end
        end
        else
        begin
            n.dot = d + 9'd1;
        end

        state_next  = n;
        tick_result = res;
    end

endmodule

FILE: sv/tvu_out_buf.sv
// Two-entry result queue between the datapath and the output channel.
// Depends on tvu_pkg.
module tvu_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tvu_pkg::tvu_result_t push_data,
    input  logic                 pop,
    output tvu_pkg::tvu_result_t head,
    output logic                 not_empty,
    output logic                 full
);
    import tvu_pkg::*;

    tvu_result_t slot0_reg;
    tvu_result_t slot1_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [1:0]  wr_idx;

    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};
    assign wr_idx     = count_reg - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // shift on pop, then write behind the last held entry
    always_ff @(posedge clk)
    begin
        if (push && !wr_idx[0])
        begin
            slot0_reg <= push_data;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
        if (push && wr_idx[0])
        begin
            slot1_reg <= push_data;
        end
    end

    assign head      = slot0_reg;
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);

endmodule

FILE: sv/tile_background_video_unit.sv
// Top level of the tile background video unit: handshake, registers, memories.
// Depends on tvu_pkg, tvu_ram, tvu_render, tvu_out_buf and the defines header.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | in        | in_valid / in_stall  | cmd, reg_select, write_data, load_addr
//  out     | out       | out_valid / out_stall| read_data, pixel_*, color_index, nmi...
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each transaction has two steps: the synchronous memory read, then the state
// update, write-back and queuing of the result. With a single memory port per
// store the steps cannot overlap, so no input is taken during the write-back.
// After reset a clearing pass over 8192 addresses zeroes the memories; no input is
// taken until it ends. A two-entry result queue lets input proceed while a
// result waits on out_stall.
`include "tile_background_video_unit_defines.svh"

module tile_background_video_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  write_data,
    input  logic [12:0] load_addr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        pixel_valid,
    output logic [7:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic [5:0]  color_index,
    output logic [23:0] pixel_rgb,
    output logic        nmi_pulse,
    output logic        frame_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import tvu_pkg::*;

    tvu_raster_t raster_reg;
    tvu_raster_t raster_next;
    tvu_raster_t tick_next;
    tvu_result_t tick_result;
    tvu_result_t res;
    tvu_result_t head;

    logic [7:0]  read_buffer_reg;
    logic [7:0]  read_buffer_next;
    logic        write_latch_reg;
    logic        write_latch_next;
    logic [7:0]  oam_index_reg;
    logic [7:0]  oam_index_next;
    logic        mirror_mode_reg;
    logic        pattern_ro_reg;
    logic        busy_reg;
    logic [12:0] clr_cnt_reg;
    logic        clr_done_reg;
    logic [7:0]  pal_mem_reg [32];

    tvu_cmd_t    item_cmd_reg;
    logic [2:0]  item_sel_reg;
    logic [7:0]  item_data_reg;
    logic [12:0] item_addr_reg;
    tvu_src_t    item_src_reg;

    logic        accept;
    logic        pop;
    logic        ob_full;
    tvu_src_t    rd_src;
    logic [12:0] pat_raddr;
    logic [10:0] nt_raddr;
    logic [8:0]  d;
    logic [8:0]  l;
    logic [8:0]  d_minus;
    logic [2:0]  phase;
    logic [15:0] v;
    logic [13:0] mem_a;
    logic        in_pat;
    logic        in_nt;
    logic [15:0] v_inc;
    logic [4:0]  pal_index;
    logic [4:0]  pal_rd_addr;
    logic [7:0]  pal_data;
    logic [7:0]  fetch_byte;
    logic        video_flags;

    logic        pat_we;
    logic        nt_we;
    logic        oam_we;
    logic        pal_we;
    logic [12:0] pat_addr;
    logic [10:0] nt_addr;
    logic [7:0]  oam_addr;
    logic [7:0]  ram_wdata;
    logic [7:0]  pat_rdata;
    logic [7:0]  nt_rdata;
    logic [7:0]  oam_rdata;

    function automatic logic [10:0] nt_slot(input logic [13:0] a, input logic mirror);
        return {(mirror ? a[11] : a[10]), a[9:0]};
    endfunction

    function automatic logic [4:0] pal_slot(input logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if (p[4] && (p[1:0] == 2'd0))
        begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

    // handshake
    assign accept    = in_valid && !in_stall;
    assign in_stall  = !clr_done_reg || busy_reg || ob_full;
    assign pop       = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    assign d       = raster_reg.dot;
    assign l       = raster_reg.line;
    assign d_minus = d - 9'd1;
    assign phase   = d_minus[2:0];
    assign v       = raster_reg.v;
    assign mem_a   = v[13:0];
    assign in_pat  = (mem_a < NT_BASE);
    assign in_nt   = !in_pat && (mem_a < PAL_BASE);
    assign v_inc   = v + (raster_reg.ctrl[2] ? 16'd32 : 16'd1);

    // read address for the incoming transaction
    always_comb
    begin
        rd_src    = SRC_NONE;
        pat_raddr = mem_a[12:0];
        nt_raddr  = nt_slot(mem_a, mirror_mode_reg);
        case (tvu_cmd_t'(cmd))
            CMD_TICK:
            begin
                if (((l < 9'd240) || (l == PRE_LINE)) &&
                    (((d >= 9'd2) && (d <= 9'd257)) || ((d >= 9'd321) && (d <= 9'd337))))
                begin
                    case (phase)
                        3'd0:
                        begin
                            rd_src   = SRC_NT;
                            nt_raddr = nt_slot({2'b10, v[11:0]}, mirror_mode_reg);
                        end
                        3'd2:
                        begin
                            rd_src   = SRC_NT;
                            nt_raddr = nt_slot({2'b10, v[11:10], 4'b1111, v[9:7], v[4:2]},
                                               mirror_mode_reg);
                        end
                        3'd4, 3'd6:
                        begin
                            rd_src    = SRC_PAT;
                            pat_raddr = {raster_reg.ctrl[4], raster_reg.tile_id, phase[1],
                                         v[14:12]};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CMD_READ:
            begin
                if (reg_select == REG_OAM_DATA)
                begin
                    rd_src = SRC_OAM;
                end
                else if (reg_select == REG_DATA)
                begin
                    rd_src = in_pat ? SRC_PAT : (in_nt ? SRC_NT : SRC_PAL);
                end
            end
            default:
            begin
            end
        endcase
    end

    // write enables in the write-back step of a transaction
    assign pat_we = busy_reg && ((item_cmd_reg == CMD_LOAD) ||
                    ((item_cmd_reg == CMD_WRITE) && (item_sel_reg == REG_DATA) &&
                     in_pat && !pattern_ro_reg));
    assign nt_we  = busy_reg && (item_cmd_reg == CMD_WRITE) && (item_sel_reg == REG_DATA) &&
                    in_nt;
    assign pal_we = busy_reg && (item_cmd_reg == CMD_WRITE) && (item_sel_reg == REG_DATA) &&
                    !in_pat && !in_nt;
    assign oam_we = busy_reg && (item_cmd_reg == CMD_WRITE) && (item_sel_reg == REG_OAM_DATA);

    // memory port muxes: clearing pass, write-back, or read
    always_comb
    begin
        if (!clr_done_reg)
        begin
            pat_addr  = clr_cnt_reg;
            nt_addr   = clr_cnt_reg[10:0];
            oam_addr  = clr_cnt_reg[7:0];
            ram_wdata = 8'd0;
        end
        else if (busy_reg)
        begin
            pat_addr  = (item_cmd_reg == CMD_LOAD) ? item_addr_reg : mem_a[12:0];
            nt_addr   = nt_slot(mem_a, mirror_mode_reg);
            oam_addr  = oam_index_reg;
            ram_wdata = item_data_reg;
        end
        else
        begin
            pat_addr  = pat_raddr;
            nt_addr   = nt_raddr;
            oam_addr  = oam_index_reg;
            ram_wdata = item_data_reg;
        end
    end

    tvu_ram #(
        .WIDTH (8),
        .DEPTH (8192)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we || !clr_done_reg),
        .addr  (pat_addr),
        .wdata (ram_wdata),
        .rdata (pat_rdata)
    );

    tvu_ram #(
        .WIDTH (8),
        .DEPTH (2048)
    ) u_nt_ram (
        .clk   (clk),
        .we    (nt_we || !clr_done_reg),
        .addr  (nt_addr),
        .wdata (ram_wdata),
        .rdata (nt_rdata)
    );

    tvu_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_oam_ram (
        .clk   (clk),
        .we    (oam_we || !clr_done_reg),
        .addr  (oam_addr),
        .wdata (ram_wdata),
        .rdata (oam_rdata)
    );

    // palette read: pixel lookup on ticks, data port otherwise
    assign pal_rd_addr = (item_cmd_reg == CMD_TICK) ? pal_index : pal_slot(mem_a);
    assign pal_data    = pal_mem_reg[pal_rd_addr];

    always_comb
    begin
        case (item_src_reg)
            SRC_PAT: fetch_byte = pat_rdata;
            SRC_NT:  fetch_byte = nt_rdata;
            SRC_OAM: fetch_byte = oam_rdata;
            SRC_PAL: fetch_byte = pal_data;
            default: fetch_byte = 8'd0;
        endcase
    end

    tvu_render u_render (
        .state       (raster_reg),
        .fetch_data  (fetch_byte),
        .pal_data    (pal_data),
        .pal_index   (pal_index),
        .state_next  (tick_next),
        .tick_result (tick_result)
    );

    // state update and result for the transaction in its write-back step
    always_comb
    begin
        raster_next      = raster_reg;
        read_buffer_next = read_buffer_reg;
        write_latch_next = write_latch_reg;
        oam_index_next   = oam_index_reg;
        res              = '0;
        case (item_cmd_reg)
            CMD_TICK:
            begin
                raster_next = tick_next;
                res         = tick_result;
            end
            CMD_READ:
            begin
                case (item_sel_reg)
                    REG_STATUS:
                    begin
                        res.read_data      = {raster_reg.vblank, 7'd0};
                        raster_next.vblank = 1'b0;
                        write_latch_next   = 1'b0;
                    end
                    REG_OAM_DATA:
                    begin
                        res.read_data = oam_rdata;
                    end
                    REG_DATA:
                    begin
                        read_buffer_next = fetch_byte;
                        res.read_data    = (mem_a >= PAL_BASE) ? fetch_byte : read_buffer_reg;
                        raster_next.v    = v_inc;
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_WRITE:
            begin
                case (item_sel_reg)
                    REG_CTRL:
                    begin
                        raster_next.ctrl       = item_data_reg;
                        raster_next.t[11:10]   = item_data_reg[1:0];
                    end
                    REG_MASK:
                    begin
                        raster_next.mask = item_data_reg;
                    end
                    REG_OAM_ADDR:
                    begin
                        oam_index_next = item_data_reg;
                    end
                    REG_OAM_DATA:
                    begin
                        oam_index_next = oam_index_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (!write_latch_reg)
                        begin
                            raster_next.fx     = item_data_reg[2:0];
                            raster_next.t[4:0] = item_data_reg[7:3];
                            write_latch_next   = 1'b1;
                        end
                        else
                        begin
                            raster_next.t[14:12] = item_data_reg[2:0];
                            raster_next.t[9:5]   = item_data_reg[7:3];
                            write_latch_next     = 1'b0;
                        end
                    end
                    REG_ADDR:
                    begin
                        if (!write_latch_reg)
                        begin
                            raster_next.t[15:8] = {2'b00, item_data_reg[5:0]};
                            write_latch_next    = 1'b1;
                        end
                        else
                        begin
                            raster_next.t[7:0] = item_data_reg;
                            raster_next.v      = {raster_reg.t[15:8], item_data_reg};
                            write_latch_next   = 1'b0;
                        end
                    end
                    REG_DATA:
                    begin
                        raster_next.v = v_inc;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_reg      <= '0;
            read_buffer_reg <= 8'd0;
            write_latch_reg <= 1'b0;
            oam_index_reg   <= 8'd0;
            mirror_mode_reg <= 1'b0;
            pattern_ro_reg  <= 1'b0;
            busy_reg        <= 1'b0;
            clr_cnt_reg     <= 13'd0;
            clr_done_reg    <= 1'b0;
            item_cmd_reg    <= CMD_TICK;
            item_src_reg    <= SRC_NONE;
            for (int i = 0; i < 32; i++)
            begin
                pal_mem_reg[i] <= 8'd0;
            end
        end
        else
        begin
            // clearing pass over the memories
            if (!clr_done_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 13'd1;
                if (clr_cnt_reg == 13'h1FFF)
                begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIRROR)
                begin
                    mirror_mode_reg <= cfg_data;
                end
                else if (cfg_index == CFG_PATTERN_RO)
                begin
                    pattern_ro_reg <= cfg_data;
                end
            end
            if (accept)
            begin
                busy_reg     <= 1'b1;
                item_cmd_reg <= tvu_cmd_t'(cmd);
                item_src_reg <= rd_src;
            end
            else if (busy_reg)
            begin
                busy_reg        <= 1'b0;
                raster_reg      <= raster_next;
                read_buffer_reg <= read_buffer_next;
                write_latch_reg <= write_latch_next;
                oam_index_reg   <= oam_index_next;
                if (pal_we)
                begin
                    pal_mem_reg[pal_slot(mem_a)] <= item_data_reg;
                end
            end
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_sel_reg  <= reg_select;
            item_data_reg <= write_data;
            item_addr_reg <= load_addr;
        end
    end

    tvu_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (busy_reg),
        .push_data (res),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .full      (ob_full)
    );

    assign read_data   = head.read_data;
    assign pixel_valid = head.pixel_valid;
    assign pixel_x     = head.pixel_x;
    assign pixel_y     = head.pixel_y;
    assign color_index = head.color_index;
    assign pixel_rgb   = head.pixel_rgb;
    assign nmi_pulse   = head.nmi_pulse;
    assign frame_done  = head.frame_done;

    // video outputs of the transaction being queued
    assign video_flags = res.pixel_valid || res.nmi_pulse || res.frame_done;

    // checks
    `TVU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy_reg)
    `TVU_ASSERT_NEXT(a_two_cycle_item, clk, rst_n, busy_reg, !busy_reg)
    `TVU_ASSERT_NEVER(a_no_out_while_clearing, clk, rst_n, !clr_done_reg && out_valid)
    `TVU_ASSERT_NEVER(a_video_on_tick_only, clk, rst_n, busy_reg && (item_cmd_reg != CMD_TICK) && video_flags)

endmodule
